// ===== design/rfcs_pkg.sv =====
// Shared types and constants for the resonant filter with cubic shaper.
`timescale 1ns / 1ps
`default_nettype none

package rfcs_pkg;

   // Fixed field formats.
   localparam int IN_W       = 24;
   localparam int IN_FRAC    = 20;
   localparam int NOISE_W    = 16;
   localparam int NOISE_FRAC = 12;
   localparam int OUT_W      = 24;
   localparam int OUT_FRAC   = 22;
   localparam int STATE_FRAC = 24;
   localparam int CFG_W      = 25;

   // Register port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam logic signed [CFG_W-1:0] POST_GAIN_RESET = 25'sd1048576;

   // Digit width of the shared multiplier.
   localparam int MUL_LIMB_W = 24;

   typedef enum logic [2:0] {
      REG_LOWPASS_GAIN   = 3'd0,
      REG_HIGHPASS_GAIN  = 3'd1,
      REG_STAGE_ONE_COEF = 3'd2,
      REG_STAGE_TWO_COEF = 3'd3,
      REG_RESONANCE_COEF = 3'd4,
      REG_NOISE_SCALE    = 3'd5,
      REG_SHAPER_SCALE   = 3'd6,
      REG_POST_GAIN      = 3'd7
   } csr_reg_type;

   // One entry per product of the per-sample sequence, in order.
   typedef enum logic [3:0] {
      OP_X_LP  = 4'd0,
      OP_FB_R  = 4'd1,
      OP_Z1_A  = 4'd2,
      OP_N1_S  = 4'd3,
      OP_ZA_B  = 4'd4,
      OP_DX_HP = 4'd5,
      OP_Z2_B  = 4'd6,
      OP_N2_S  = 4'd7,
      OP_ZB_N  = 4'd8,
      OP_NX_NX = 4'd9,
      OP_SQ_NX = 4'd10,
      OP_N3_S  = 4'd11,
      OP_ZY_PG = 4'd12
   } op_type;

endpackage

`default_nettype wire

// ===== design/rfcs_mul.sv =====
// Multi-cycle signed multiplier that consumes the first operand one digit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rfcs_mul #(
   parameter int A_W = 34,
   parameter int B_W = 30
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [A_W-1:0]       a_in,
   input  logic signed [B_W-1:0]       b_in,
   output logic                        busy,
   output logic signed [A_W+B_W-1:0]   product
);

   localparam int LIMB_W = rfcs_pkg::MUL_LIMB_W;
   localparam int NL     = (A_W + LIMB_W - 1) / LIMB_W;
   localparam int EXT_W  = NL * LIMB_W;
   localparam int ACC_W  = EXT_W + B_W;
   localparam int PART_W = LIMB_W + 1 + B_W;
   localparam int CNT_W  = (NL > 1) ? $clog2(NL) : 1;

   logic [EXT_W-1:0]         a_ff;
   logic signed [B_W-1:0]    b_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic [CNT_W-1:0]         limb_ff;
   logic                     busy_ff;
   logic [LIMB_W-1:0]        top_limb;
   logic                     first_limb;
   logic signed [LIMB_W:0]   digit;
   logic signed [PART_W-1:0] part;

   // Most significant digit first; only that digit carries the sign.
   assign top_limb   = a_ff[EXT_W-1 -: LIMB_W];
   assign first_limb = (limb_ff == CNT_W'(NL - 1));
   assign digit      = $signed({first_limb & top_limb[LIMB_W-1], top_limb});
   assign part       = digit * b_ff;
   assign acc_in     = (acc_ff <<< LIMB_W) + ACC_W'(part);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         limb_ff <= '0;
      end else if (start) begin
         a_ff    <= EXT_W'(a_in);
         b_ff    <= b_in;
         acc_ff  <= '0;
         limb_ff <= CNT_W'(NL - 1);
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         a_ff   <= a_ff << LIMB_W;
         acc_ff <= acc_in;
         if (limb_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            limb_ff <= limb_ff - CNT_W'(1);
         end
      end
   end

   assign busy    = busy_ff;
   assign product = $signed(acc_ff[A_W+B_W-1:0]);

endmodule

`default_nettype wire

// ===== design/resonant_filter_with_cubic_shaper.sv =====
// Top level of the two-integrator resonant filter with a cubic soft-clip shaper.
//
//   Channel  Dir  Handshake          Contents of one beat
//   req      in   req_valid/ready    sample_in Q3.20, three Q3.12 noise values
//   rsp      out  rsp_valid/ready    sample_out Q1.22, saturated
//   csr      in   APB, pready = 1    eight Q4.20 coefficient registers
//
// Each sample runs thirteen products through one shared multiplier: a load step, the
// digit steps of the multiplier (NL digits: operand width over the 24-bit digit, two
// at the defaults) and a step to scale and accumulate.
// Reset is synchronous; it zeroes the filter state and restores the registers.
// The result sits in an output register, so the next beat is accepted while it waits;
// the last product of that beat holds until the output register has been emptied.
`timescale 1ns / 1ps
`default_nettype none

module resonant_filter_with_cubic_shaper #(
   parameter int COEF_FRAC_BITS = 20,
   parameter int STATE_WIDTH    = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rfcs_pkg::IN_W-1:0]      req_sample_in,
   input  logic signed [rfcs_pkg::NOISE_W-1:0]   req_noise_first,
   input  logic signed [rfcs_pkg::NOISE_W-1:0]   req_noise_second,
   input  logic signed [rfcs_pkg::NOISE_W-1:0]   req_noise_third,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rfcs_pkg::OUT_W-1:0]     rsp_sample_out,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rfcs_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [rfcs_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [rfcs_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int C     = COEF_FRAC_BITS;
   localparam int SW    = STATE_WIDTH;
   localparam int CFG_W = rfcs_pkg::CFG_W;
   localparam int SFRAC = rfcs_pkg::STATE_FRAC;

   // The shaper input is clipped to one, so N*zb is bounded by the register
   // range times one; its square and cube widths follow from that.
   localparam int NX_W   = CFG_W + SFRAC - C + 1;
   localparam int SQ_W   = 2 * (NX_W - 2) - SFRAC + 2;
   localparam int ONEC_W = (C + 2 > CFG_W + 1) ? C + 2 : CFG_W + 1;
   localparam int B_W    = (NX_W > ONEC_W) ? NX_W : ONEC_W;
   localparam int A_W0   = (SW + 1 > SQ_W) ? SW + 1 : SQ_W;
   localparam int A_W1   = (A_W0 > NX_W) ? A_W0 : NX_W;
   localparam int A_W    = (A_W1 > rfcs_pkg::IN_W + 1) ? A_W1 : rfcs_pkg::IN_W + 1;
   localparam int P_W    = A_W + B_W;
   localparam int SUM_W  = P_W + 3;
   localparam int OUT_W  = rfcs_pkg::OUT_W;

   // Scaling of each product back to its target format.
   localparam int SH_IN    = C + rfcs_pkg::IN_FRAC - SFRAC;
   localparam int SH_NOISE = C + rfcs_pkg::NOISE_FRAC - SFRAC;
   localparam int SH_OUT   = SFRAC + C - rfcs_pkg::OUT_FRAC;

   localparam logic signed [B_W-1:0] ONE_COEF = B_W'(1) << C;

   localparam logic signed [SUM_W-1:0] ST_MAX =
      {{(SUM_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ST_MIN =
      {{(SUM_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}};
   localparam logic signed [SUM_W-1:0] ONE_STATE = SUM_W'(1) << SFRAC;
   localparam logic signed [SUM_W-1:0] ZB_HI = (ONE_STATE > ST_MAX) ? ST_MAX : ONE_STATE;
   localparam logic signed [SUM_W-1:0] ZB_LO = (-ONE_STATE < ST_MIN) ? ST_MIN : -ONE_STATE;

   localparam logic signed [P_W-1:0] OUT_MAX =
      {{(P_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
   localparam logic signed [P_W-1:0] OUT_MIN =
      {{(P_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_MUL
   } state_type;

   state_type            state_ff;
   rfcs_pkg::op_type     op_ff;

   // Coefficient registers.
   logic signed [CFG_W-1:0] lowpass_gain_ff;
   logic signed [CFG_W-1:0] highpass_gain_ff;
   logic signed [CFG_W-1:0] stage_one_coef_ff;
   logic signed [CFG_W-1:0] stage_two_coef_ff;
   logic signed [CFG_W-1:0] resonance_coef_ff;
   logic signed [CFG_W-1:0] noise_scale_ff;
   logic signed [CFG_W-1:0] shaper_scale_ff;
   logic signed [CFG_W-1:0] post_gain_ff;

   // Filter state.
   logic signed [SW-1:0]             integ_one_ff;
   logic signed [SW-1:0]             integ_two_ff;
   logic signed [SW-1:0]             shaped_out_ff;
   logic signed [SW-1:0]             prev_feedback_ff;
   logic signed [rfcs_pkg::IN_W-1:0] prev_input_ff;

   // Current beat and intermediate values.
   logic signed [rfcs_pkg::IN_W-1:0]    x_ff;
   logic signed [rfcs_pkg::NOISE_W-1:0] n1_ff;
   logic signed [rfcs_pkg::NOISE_W-1:0] n2_ff;
   logic signed [rfcs_pkg::NOISE_W-1:0] n3_ff;
   logic signed [NX_W-1:0]              nx_ff;
   logic signed [SQ_W-1:0]              sq_ff;
   logic signed [SUM_W-1:0]             sum_ff;

   logic                      rsp_valid_ff;
   logic signed [OUT_W-1:0]   rsp_sample_out_ff;

   logic                      mul_start;
   logic                      mul_busy;
   logic signed [A_W-1:0]     opa;
   logic signed [B_W-1:0]     opb;
   logic signed [P_W-1:0]     product;
   logic signed [P_W-1:0]     term;
   logic signed [SUM_W-1:0]   sum_add;
   logic signed [SUM_W-1:0]   cube_sum;
   logic signed [SW-1:0]      state_sat;
   logic signed [SW-1:0]      integ_two_in;
   logic signed [OUT_W-1:0]   rsp_sample_out_in;
   logic                      csr_write;
   rfcs_pkg::csr_reg_type     csr_index;
   logic                      out_free;
   logic                      rsp_load;

   // ---------------------------------------------------------------------
   // Register port. Writes land when the access phase completes; reads are
   // returned sign-extended from the 25-bit register.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = rfcs_pkg::csr_reg_type'(csr_paddr[rfcs_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      unique case (csr_index)
         rfcs_pkg::REG_LOWPASS_GAIN:   csr_prdata = rfcs_pkg::CSR_DATA_W'(lowpass_gain_ff);
         rfcs_pkg::REG_HIGHPASS_GAIN:  csr_prdata = rfcs_pkg::CSR_DATA_W'(highpass_gain_ff);
         rfcs_pkg::REG_STAGE_ONE_COEF: csr_prdata = rfcs_pkg::CSR_DATA_W'(stage_one_coef_ff);
         rfcs_pkg::REG_STAGE_TWO_COEF: csr_prdata = rfcs_pkg::CSR_DATA_W'(stage_two_coef_ff);
         rfcs_pkg::REG_RESONANCE_COEF: csr_prdata = rfcs_pkg::CSR_DATA_W'(resonance_coef_ff);
         rfcs_pkg::REG_NOISE_SCALE:    csr_prdata = rfcs_pkg::CSR_DATA_W'(noise_scale_ff);
         rfcs_pkg::REG_SHAPER_SCALE:   csr_prdata = rfcs_pkg::CSR_DATA_W'(shaper_scale_ff);
         rfcs_pkg::REG_POST_GAIN:      csr_prdata = rfcs_pkg::CSR_DATA_W'(post_gain_ff);
      endcase
   end

   // ---------------------------------------------------------------------
   // Operand selection for the shared multiplier. Stage one builds za from
   // four products, stage two builds zb from four more, then the shaper
   // forms N*zb, its square and cube, the third noise term and finally the
   // output gain. Stage two reads integ_one after it already holds za.
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (op_ff)
         rfcs_pkg::OP_X_LP: begin
            opa = A_W'(x_ff);
            opb = B_W'(lowpass_gain_ff);
         end
         rfcs_pkg::OP_FB_R: begin
            opa = A_W'(shaped_out_ff) - A_W'(prev_feedback_ff);
            opb = B_W'(resonance_coef_ff);
         end
         rfcs_pkg::OP_Z1_A: begin
            opa = A_W'(integ_one_ff);
            opb = B_W'(stage_one_coef_ff);
         end
         rfcs_pkg::OP_N1_S: begin
            opa = A_W'(n1_ff);
            opb = B_W'(noise_scale_ff);
         end
         rfcs_pkg::OP_ZA_B: begin
            opa = A_W'(integ_one_ff);
            opb = ONE_COEF - B_W'(stage_two_coef_ff);
         end
         rfcs_pkg::OP_DX_HP: begin
            opa = A_W'(x_ff) - A_W'(prev_input_ff);
            opb = B_W'(highpass_gain_ff);
         end
         rfcs_pkg::OP_Z2_B: begin
            opa = A_W'(integ_two_ff);
            opb = B_W'(stage_two_coef_ff);
         end
         rfcs_pkg::OP_N2_S: begin
            opa = A_W'(n2_ff);
            opb = B_W'(noise_scale_ff);
         end
         rfcs_pkg::OP_ZB_N: begin
            opa = A_W'(integ_two_ff);
            opb = B_W'(shaper_scale_ff);
         end
         rfcs_pkg::OP_NX_NX: begin
            opa = A_W'(nx_ff);
            opb = B_W'(nx_ff);
         end
         rfcs_pkg::OP_SQ_NX: begin
            opa = A_W'(sq_ff);
            opb = B_W'(nx_ff);
         end
         rfcs_pkg::OP_N3_S: begin
            opa = A_W'(n3_ff);
            opb = B_W'(noise_scale_ff);
         end
         rfcs_pkg::OP_ZY_PG: begin
            opa = A_W'(shaped_out_ff);
            opb = B_W'(post_gain_ff);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign mul_start = (state_ff == S_LOAD);

   rfcs_mul #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_in    (opa),
      .b_in    (opb),
      .busy    (mul_busy),
      .product (product)
   );

   // ---------------------------------------------------------------------
   // Scaling. Every product is floored to its target format, which an
   // arithmetic right shift of the exact product does.
   // ---------------------------------------------------------------------
   always_comb begin
      case (op_ff) inside
         rfcs_pkg::OP_X_LP, rfcs_pkg::OP_DX_HP:                  term = product >>> SH_IN;
         rfcs_pkg::OP_N1_S, rfcs_pkg::OP_N2_S, rfcs_pkg::OP_N3_S: term = product >>> SH_NOISE;
         rfcs_pkg::OP_NX_NX, rfcs_pkg::OP_SQ_NX:                 term = product >>> SFRAC;
         rfcs_pkg::OP_ZY_PG:                                     term = product >>> SH_OUT;
         default:                                                term = product >>> C;
      endcase
   end

   assign sum_add  = sum_ff + SUM_W'(term);
   assign cube_sum = SUM_W'(integ_two_ff) - (SUM_W'(term) <<< 1);

   // Saturation of za and zy to the state range.
   always_comb begin
      if (sum_add > ST_MAX) begin
         state_sat = ST_MAX[SW-1:0];
      end else if (sum_add < ST_MIN) begin
         state_sat = ST_MIN[SW-1:0];
      end else begin
         state_sat = sum_add[SW-1:0];
      end
   end

   // The second integrator is clipped to plus or minus one, and to the
   // state range where that is narrower.
   always_comb begin
      if (sum_add > ZB_HI) begin
         integ_two_in = ZB_HI[SW-1:0];
      end else if (sum_add < ZB_LO) begin
         integ_two_in = ZB_LO[SW-1:0];
      end else begin
         integ_two_in = sum_add[SW-1:0];
      end
   end

   always_comb begin
      if (term > OUT_MAX) begin
         rsp_sample_out_in = OUT_MAX[OUT_W-1:0];
      end else if (term < OUT_MIN) begin
         rsp_sample_out_in = OUT_MIN[OUT_W-1:0];
      end else begin
         rsp_sample_out_in = term[OUT_W-1:0];
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_ready;

   // The output register loads when the last product is done and has room.
   assign rsp_load = (state_ff == S_MUL) && !mul_busy &&
                     (op_ff == rfcs_pkg::OP_ZY_PG) && out_free;

   // ---------------------------------------------------------------------
   // Sequencer, filter state and output register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         op_ff             <= rfcs_pkg::OP_X_LP;
         rsp_valid_ff      <= 1'b0;
         lowpass_gain_ff   <= '0;
         highpass_gain_ff  <= '0;
         stage_one_coef_ff <= '0;
         stage_two_coef_ff <= '0;
         resonance_coef_ff <= '0;
         noise_scale_ff    <= '0;
         shaper_scale_ff   <= '0;
         post_gain_ff      <= rfcs_pkg::POST_GAIN_RESET;
         integ_one_ff      <= '0;
         integ_two_ff      <= '0;
         shaped_out_ff     <= '0;
         prev_feedback_ff  <= '0;
         prev_input_ff     <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write) begin
            unique case (csr_index)
               rfcs_pkg::REG_LOWPASS_GAIN:   lowpass_gain_ff   <= $signed(csr_pwdata[CFG_W-1:0]);
               rfcs_pkg::REG_HIGHPASS_GAIN:  highpass_gain_ff  <= $signed(csr_pwdata[CFG_W-1:0]);
               rfcs_pkg::REG_STAGE_ONE_COEF: stage_one_coef_ff <= $signed(csr_pwdata[CFG_W-1:0]);
               rfcs_pkg::REG_STAGE_TWO_COEF: stage_two_coef_ff <= $signed(csr_pwdata[CFG_W-1:0]);
               rfcs_pkg::REG_RESONANCE_COEF: resonance_coef_ff <= $signed(csr_pwdata[CFG_W-1:0]);
               rfcs_pkg::REG_NOISE_SCALE:    noise_scale_ff    <= $signed(csr_pwdata[CFG_W-1:0]);
               rfcs_pkg::REG_SHAPER_SCALE:   shaper_scale_ff   <= $signed(csr_pwdata[CFG_W-1:0]);
               rfcs_pkg::REG_POST_GAIN:      post_gain_ff      <= $signed(csr_pwdata[CFG_W-1:0]);
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff     <= req_sample_in;
                  n1_ff    <= req_noise_first;
                  n2_ff    <= req_noise_second;
                  n3_ff    <= req_noise_third;
                  sum_ff   <= '0;
                  op_ff    <= rfcs_pkg::OP_X_LP;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (!mul_busy) begin
                  if (op_ff == rfcs_pkg::OP_ZY_PG) begin
                     // Last product: wait here until the output register is free.
                     if (out_free) begin
                        rsp_sample_out_ff <= rsp_sample_out_in;
                        state_ff          <= S_IDLE;
                     end
                  end else begin
                     case (op_ff)
                        rfcs_pkg::OP_N1_S: begin
                           integ_one_ff <= state_sat;
                           sum_ff       <= '0;
                        end
                        rfcs_pkg::OP_N2_S: begin
                           integ_two_ff <= integ_two_in;
                           sum_ff       <= '0;
                        end
                        rfcs_pkg::OP_ZB_N: begin
                           nx_ff <= term[NX_W-1:0];
                        end
                        rfcs_pkg::OP_NX_NX: begin
                           sq_ff <= term[SQ_W-1:0];
                        end
                        rfcs_pkg::OP_SQ_NX: begin
                           sum_ff <= cube_sum;
                        end
                        rfcs_pkg::OP_N3_S: begin
                           // Commit the shaper output and the delay taps.
                           shaped_out_ff    <= state_sat;
                           prev_feedback_ff <= shaped_out_ff;
                           prev_input_ff    <= x_ff;
                        end
                        default: begin
                           sum_ff <= sum_add;
                        end
                     endcase
                     op_ff    <= rfcs_pkg::op_type'(op_ff + 4'd1);
                     state_ff <= S_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

endmodule

`default_nettype wire

// ===== design/rfcs_checker.sv =====
// Port-level assertions for the resonant filter, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module rfcs_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [rfcs_pkg::OUT_W-1:0]     rsp_sample_out,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rfcs_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [rfcs_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   input  logic [rfcs_pkg::CSR_DATA_W-1:0]       csr_prdata,
   input  logic                                  csr_pready
);

   // A waiting result beat is held until taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("result beat changed while stalled");

   // After reset the block is idle and empty.
   assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // The block works on one beat at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while busy");

   // A result needs the whole product sequence and cannot rise straight after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result appeared too early");

   // A register read right after a write returns the written value.
   assert property (@(posedge clock) disable iff (reset)
      ((csr_psel && csr_penable && csr_pwrite && csr_pready) ##1
       (csr_psel && !csr_pwrite && csr_paddr[4:2] == $past(csr_paddr[4:2])))
      |-> (csr_prdata == {{7{$past(csr_pwdata[24])}}, $past(csr_pwdata[24:0])}))
      else $error("register read-back mismatch");

endmodule

bind resonant_filter_with_cubic_shaper rfcs_checker u_rfcs_checker (.*);

`default_nettype wire
